### src/lbc_pkg.sv
// Shared types and constants for the Liang-Barsky line clipper.
// No dependencies; every other source file refers to this package.
package lbc_pkg;

   localparam int COORD_W    = 16;
   localparam int DIV_STAGES = 17;       // one quotient bit per stage
   localparam int CSR_ADDR_W = 4;

   localparam logic [16:0]        UNIT_Q16 = 17'h10000;
   localparam logic signed [17:0] R_HIGH   = 18'sd65537;   // above any u
   localparam logic signed [17:0] R_LOW    = -18'sd1;      // below any u

   localparam logic [1:0] REG_LEFT   = 2'd0;
   localparam logic [1:0] REG_RIGHT  = 2'd1;
   localparam logic [1:0] REG_BOTTOM = 2'd2;
   localparam logic [1:0] REG_TOP    = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic signed [COORD_W-1:0] clipped_start_x;
      logic signed [COORD_W-1:0] clipped_start_y;
      logic signed [COORD_W-1:0] clipped_end_x;
      logic signed [COORD_W-1:0] clipped_end_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
      logic signed [COORD_W-1:0] top;
   } window_type;

   // one window edge, already split into sign and magnitude
   typedef struct packed {
      logic        pzero;
      logic        pneg;
      logic        qneg;
      logic [15:0] an;   // |q|
      logic [15:0] ad;   // |p|
   } edge_type;

   typedef struct packed {
      req_type            seg;
      edge_type [3:0]     edges;
   } item_type;

   typedef struct packed {
      logic        pzero;
      logic        pneg;
      logic        qneg;
      logic        ovf;
      logic [15:0] ad;
      logic [16:0] rem;
      logic [16:0] quo;
   } dv_stage_type;

   typedef struct packed {
      logic               pzero;
      logic               pneg;
      logic               qneg;
      logic signed [17:0] r;     // q/p in Q.16, clamped to [-1, 65537]
   } div_out_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

### src/lbc_front.sv
// Front end: takes a segment and forms p/q magnitudes and signs per edge.
// Depends on lbc_pkg.
module lbc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lbc_pkg::req_type    req_data,
   input  lbc_pkg::window_type window,
   input  logic                take,
   output logic                item_valid,
   output lbc_pkg::item_type   item
);

   logic              vld_ff, vld_in;
   lbc_pkg::item_type item_ff, item_in;
   logic              accept;

   function automatic lbc_pkg::edge_type mk_edge(input logic signed [16:0] p,
                                                 input logic signed [16:0] q);
      lbc_pkg::edge_type e;
      logic [16:0]       pa, qa;
      pa = p[16] ? 17'(-p) : 17'(p);
      qa = q[16] ? 17'(-q) : 17'(q);
      e.pzero = (p == 17'sd0);
      e.pneg  = p[16];
      e.qneg  = q[16];
      e.an    = qa[15:0];
      e.ad    = pa[15:0];
      return e;
   endfunction

   always_comb begin
      logic signed [16:0] x1, y1, x2, y2, dx, dy;
      x1 = 17'(req_data.start_x);
      y1 = 17'(req_data.start_y);
      x2 = 17'(req_data.end_x);
      y2 = 17'(req_data.end_y);
      dx = x2 - x1;
      dy = y2 - y1;
      item_in.seg      = req_data;
      item_in.edges[0] = mk_edge(-dx, x1 - 17'(window.left));
      item_in.edges[1] = mk_edge(dx, 17'(window.right) - x1);
      item_in.edges[2] = mk_edge(-dy, y1 - 17'(window.bottom));
      item_in.edges[3] = mk_edge(dy, 17'(window.top) - y1);
   end

   assign busy   = vld_ff && !take;
   assign accept = start && !busy;
   assign vld_in = accept || (vld_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

### src/lbc_fifo.sv
// Short queue between the front end and the clipping pipeline.
// Depends on lbc_pkg.
module lbc_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lbc_pkg::item_type       push_data,
   input  logic                    pop,
   output lbc_pkg::item_type       head,
   output lbc_pkg::fifo_stat_type  stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

   lbc_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign do_push = push && (cnt_ff != FULLC);
   assign do_pop  = pop && (cnt_ff != '0);

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign head       = mem_ff[rd_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == FULLC);

endmodule

### src/lbc_divider.sv
// Pipelined restoring divider for one edge: r = round(q * 2^16 / p),
// clamped to [-1, 65537]. One quotient bit per stage; depends on lbc_pkg.
module lbc_divider (
   input  logic                  clock,
   input  lbc_pkg::edge_type     edge_in,
   output lbc_pkg::div_out_type  result
);

   localparam int NS = lbc_pkg::DIV_STAGES;

   lbc_pkg::dv_stage_type stage_ff [NS];
   lbc_pkg::dv_stage_type stage_in [NS];
   lbc_pkg::dv_stage_type first;

   // numerator is {an, 0, ad}, divisor 2*ad: rounding folded in
   function automatic lbc_pkg::dv_stage_type step(input lbc_pkg::dv_stage_type s,
                                                  input logic nbit);
      lbc_pkg::dv_stage_type o;
      logic [17:0] t, dd;
      logic        ge;
      t  = {s.rem, nbit};
      dd = {1'b0, s.ad, 1'b0};
      ge = (t >= dd);
      o      = s;
      o.rem  = ge ? 17'(t - dd) : t[16:0];
      o.quo  = {s.quo[15:0], ge};
      return o;
   endfunction

   always_comb begin
      first.pzero = edge_in.pzero;
      first.pneg  = edge_in.pneg;
      first.qneg  = edge_in.qneg;
      first.ad    = edge_in.ad;
      first.rem   = {1'b0, edge_in.an};
      first.quo   = '0;
      first.ovf   = ({1'b0, edge_in.an} >= {edge_in.ad, 1'b0});
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int BI = NS - 1 - s;
      if (s == 0) begin : g_first
         if (BI >= 16) begin : g_zero
            assign stage_in[s] = step(first, 1'b0);
         end else begin : g_bit
            assign stage_in[s] = step(first, first.ad[BI]);
         end
      end else begin : g_next
         if (BI >= 16) begin : g_zero
            assign stage_in[s] = step(stage_ff[s-1], 1'b0);
         end else begin : g_bit
            assign stage_in[s] = step(stage_ff[s-1], stage_ff[s-1].ad[BI]);
         end
      end
      always_ff @(posedge clock) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   always_comb begin
      lbc_pkg::dv_stage_type l;
      l = stage_ff[NS-1];
      result.pzero = l.pzero;
      result.pneg  = l.pneg;
      result.qneg  = l.qneg;
      if (l.pneg ^ l.qneg) begin
         result.r = (l.quo == '0 && !l.ovf) ? 18'sd0 : lbc_pkg::R_LOW;
      end else if (l.ovf || l.quo > lbc_pkg::UNIT_Q16) begin
         result.r = lbc_pkg::R_HIGH;
      end else begin
         result.r = $signed({1'b0, l.quo});
      end
   end

endmodule

### src/lbc_back.sv
// Clipping pipeline: a divider for each window edge, u1/u2 tightening, endpoint moves.
// Depends on lbc_pkg and lbc_divider.
module lbc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lbc_pkg::item_type  item,
   output logic               rsp_valid,
   output lbc_pkg::rsp_type   rsp_data
);

   localparam int NS = lbc_pkg::DIV_STAGES;

   lbc_pkg::div_out_type dres [4];
   logic                 vld_ff [NS];
   lbc_pkg::req_type     seg_ff [NS];

   logic                      c_vld_ff, c_ok_ff, c_ok_in;
   logic [16:0]               c_u1_ff, c_u2_ff, c_u1_in, c_u2_in;
   lbc_pkg::req_type          c_seg_ff;
   logic signed [16:0]        c_dx_ff, c_dy_ff;

   logic                      m_vld_ff, m_ok_ff, m_mv1_ff, m_mv2_ff;
   lbc_pkg::req_type          m_seg_ff;
   logic signed [34:0]        m_px1_ff, m_py1_ff, m_px2_ff, m_py2_ff;

   logic                      o_vld_ff;
   lbc_pkg::rsp_type          o_rsp_ff, o_rsp_in;

   for (genvar e = 0; e < 4; e++) begin : g_edge
      lbc_divider u_div (
         .clock   (clock),
         .edge_in (item.edges[e]),
         .result  (dres[e])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < NS; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
      seg_ff[0] <= item.seg;
      for (int s = 1; s < NS; s++) begin
         seg_ff[s] <= seg_ff[s-1];
      end
   end

   // edges in order left, right, bottom, top
   always_comb begin
      logic signed [17:0] u1, u2;
      u1      = 18'sd0;
      u2      = $signed({1'b0, lbc_pkg::UNIT_Q16});
      c_ok_in = 1'b1;
      for (int e = 0; e < 4; e++) begin
         if (dres[e].pzero) begin
            if (dres[e].qneg) c_ok_in = 1'b0;
         end else if (dres[e].pneg) begin
            if (dres[e].r > u2)      c_ok_in = 1'b0;
            else if (dres[e].r > u1) u1 = dres[e].r;
         end else begin
            if (dres[e].r < u1)      c_ok_in = 1'b0;
            else if (dres[e].r < u2) u2 = dres[e].r;
         end
      end
      c_u1_in = u1[16:0];
      c_u2_in = u2[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= vld_ff[NS-1];
      end
      c_ok_ff  <= c_ok_in;
      c_u1_ff  <= c_u1_in;
      c_u2_ff  <= c_u2_in;
      c_seg_ff <= seg_ff[NS-1];
      c_dx_ff  <= 17'(seg_ff[NS-1].end_x) - 17'(seg_ff[NS-1].start_x);
      c_dy_ff  <= 17'(seg_ff[NS-1].end_y) - 17'(seg_ff[NS-1].start_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= c_vld_ff;
      end
      m_ok_ff  <= c_ok_ff;
      m_mv1_ff <= (c_u1_ff != '0);
      m_mv2_ff <= (c_u2_ff != lbc_pkg::UNIT_Q16);
      m_seg_ff <= c_seg_ff;
      m_px1_ff <= $signed({1'b0, c_u1_ff}) * c_dx_ff;
      m_py1_ff <= $signed({1'b0, c_u1_ff}) * c_dy_ff;
      m_px2_ff <= $signed({1'b0, c_u2_ff}) * c_dx_ff;
      m_py2_ff <= $signed({1'b0, c_u2_ff}) * c_dy_ff;
   end

   // a + round(prod / 2^16), ties away from zero
   function automatic logic signed [15:0] move(input logic signed [15:0] a,
                                               input logic signed [34:0] prod);
      logic [34:0]        ap, t;
      logic signed [34:0] r;
      ap = prod[34] ? 35'(-prod) : 35'(prod);
      t  = (ap + 35'd32768) >> 16;
      r  = prod[34] ? -$signed(t) : $signed(t);
      return 16'(35'(a) + r);
   endfunction

   always_comb begin
      o_rsp_in.accepted        = m_ok_ff;
      o_rsp_in.clipped_start_x = m_seg_ff.start_x;
      o_rsp_in.clipped_start_y = m_seg_ff.start_y;
      o_rsp_in.clipped_end_x   = m_seg_ff.end_x;
      o_rsp_in.clipped_end_y   = m_seg_ff.end_y;
      if (m_ok_ff && m_mv1_ff) begin
         o_rsp_in.clipped_start_x = move(m_seg_ff.start_x, m_px1_ff);
         o_rsp_in.clipped_start_y = move(m_seg_ff.start_y, m_py1_ff);
      end
      if (m_ok_ff && m_mv2_ff) begin
         o_rsp_in.clipped_end_x = move(m_seg_ff.start_x, m_px2_ff);
         o_rsp_in.clipped_end_y = move(m_seg_ff.start_y, m_py2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= m_vld_ff;
      end
      o_rsp_ff <= o_rsp_in;
   end

   assign rsp_valid = o_vld_ff;
   assign rsp_data  = o_rsp_ff;

endmodule

### src/liang_barsky_line_clipper.sv
// Top level of the Liang-Barsky line clipper: window registers, APB port.
// Depends on lbc_pkg, lbc_front, lbc_fifo, lbc_back.
//
// Clips one 2-D segment per clock while busy is low, against the window
// held in four APB registers (left 0x0, right 0x4, bottom 0x8, top 0xC,
// signed Q2.14 in the low 16 bits; reads return the value sign-extended).
// A segment is taken at a clock edge where start is high and busy is low;
// the block takes a new segment every cycle while busy is low. Its result
// appears on rsp_data with rsp_valid high for exactly one cycle, in input
// order. Each segment passes through the front register, the queue, the
// per-edge restoring dividers (17 stages, one quotient bit each), the
// tighten stage, the multiply stage and the output register. The result
// side has no back pressure, so with a queue deeper than one the queue
// behind the front register never fills and busy stays low in normal use.
// Write the window only while no segment is in flight. A rejected segment
// comes back with accepted low and its endpoints unchanged.
module liang_barsky_line_clipper #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  lbc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output lbc_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lbc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   lbc_pkg::window_type     win_ff;
   logic                    csr_wr;
   logic [1:0]              csr_idx;

   logic                    f_valid;
   lbc_pkg::item_type       f_item;
   lbc_pkg::item_type       q_head;
   lbc_pkg::fifo_stat_type  q_stat;
   logic                    q_pop;

   // register file
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.left   <= -16'sd16384;
         win_ff.right  <= 16'sd16383;
         win_ff.bottom <= -16'sd16384;
         win_ff.top    <= 16'sd16383;
      end else if (csr_wr) begin
         case (csr_idx)
            lbc_pkg::REG_LEFT:   win_ff.left   <= pwdata[15:0];
            lbc_pkg::REG_RIGHT:  win_ff.right  <= pwdata[15:0];
            lbc_pkg::REG_BOTTOM: win_ff.bottom <= pwdata[15:0];
            lbc_pkg::REG_TOP:    win_ff.top    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         lbc_pkg::REG_LEFT:   prdata = 32'(win_ff.left);
         lbc_pkg::REG_RIGHT:  prdata = 32'(win_ff.right);
         lbc_pkg::REG_BOTTOM: prdata = 32'(win_ff.bottom);
         lbc_pkg::REG_TOP:    prdata = 32'(win_ff.top);
         default:             prdata = '0;
      endcase
   end

   // front: accept and classify
   lbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .window     (win_ff),
      .take       (!q_stat.full),
      .item_valid (f_valid),
      .item       (f_item)
   );

   // back drains the queue every cycle it holds a word
   assign q_pop = !q_stat.empty;

   lbc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_item),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   lbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_pop),
      .item      (q_head),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   localparam int LATENCY = lbc_pkg::DIV_STAGES + 5;

   // the pipeline never stalls, so a queue deeper than one never fills
   a_queue_not_full: assert property (@(posedge clock) disable iff (reset)
      !q_stat.full)
      else $error("clip queue full");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after pipeline latency");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   a_front_drains: assert property (@(posedge clock) disable iff (reset)
      f_valid |=> !f_valid || $past(start && !busy))
      else $error("front word held");

endmodule

### tb/liang_barsky_line_clipper_test.sv
// Self-checking testbench for the Liang-Barsky line clipper.
// Depends on lbc_pkg and the liang_barsky_line_clipper RTL.
module liang_barsky_line_clipper_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD = 6;
   localparam int LATENCY     = 22;
   localparam longint UNIT    = 65536;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   lbc_pkg::req_type req_data = '0;
   logic        rsp_valid;
   lbc_pkg::rsp_type rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [lbc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // window as the predictor sees it; updated at the APB write edge
   lbc_pkg::window_type win;
   lbc_pkg::req_type    pending_segs[$];
   lbc_pkg::rsp_type    clipped_due[$];
   int          errors = 0;
   int          seg_count = 0;
   int          rsp_count = 0;
   int          accept_count = 0;
   int          gap_left = 0;
   bit          calm = 1'b0;

   liang_barsky_line_clipper dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // n/d rounded to nearest, ties away from zero
   function automatic longint div_nearest(longint n, longint d);
      longint an, ad, qt;
      bit neg;
      neg = (n < 0) != (d < 0);
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      qt = (2 * an + ad) / (2 * ad);
      return neg ? -qt : qt;
   endfunction

   // one window edge: narrows [u_in, u_out], returns 0 on rejection
   function automatic bit edge_ok(longint p, longint q, ref longint u_in,
                                  ref longint u_out);
      longint r;
      if (p == 0) return q >= 0;
      r = div_nearest(q * UNIT, p);
      if (p < 0) begin
         if (r > u_out) return 1'b0;
         if (r > u_in) u_in = r;
      end else begin
         if (r < u_in) return 1'b0;
         if (r < u_out) u_out = r;
      end
      return 1'b1;
   endfunction

   function automatic lbc_pkg::rsp_type clip_segment(lbc_pkg::req_type s,
                                                     lbc_pkg::window_type w);
      longint x1, y1, dx, dy, u_in, u_out;
      bit ok;
      lbc_pkg::rsp_type o;
      x1 = s.start_x;
      y1 = s.start_y;
      dx = longint'(s.end_x) - x1;
      dy = longint'(s.end_y) - y1;
      u_in = 0;
      u_out = UNIT;
      o.accepted = 1'b0;
      o.clipped_start_x = s.start_x;
      o.clipped_start_y = s.start_y;
      o.clipped_end_x = s.end_x;
      o.clipped_end_y = s.end_y;
      ok = edge_ok(-dx, x1 - w.left, u_in, u_out)
        && edge_ok(dx, longint'(w.right) - x1, u_in, u_out)
        && edge_ok(-dy, y1 - w.bottom, u_in, u_out)
        && edge_ok(dy, longint'(w.top) - y1, u_in, u_out);
      if (ok) begin
         o.accepted = 1'b1;
         if (u_out < UNIT) begin
            o.clipped_end_x = 16'(x1 + div_nearest(u_out * dx, UNIT));
            o.clipped_end_y = 16'(y1 + div_nearest(u_out * dy, UNIT));
         end
         if (u_in > 0) begin
            o.clipped_start_x = 16'(x1 + div_nearest(u_in * dx, UNIT));
            o.clipped_start_y = 16'(y1 + div_nearest(u_in * dy, UNIT));
         end
      end
      return o;
   endfunction

   // driver: an accepted word is predicted at once; the next one follows,
   // possibly after a random idle burst
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            clipped_due = {clipped_due, clip_segment(req_data, win)};
            seg_count++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
               gap_left = $urandom_range(0, 11);
               start <= 1'b0;
            end else if (pending_segs.size() > 0) begin
               start <= 1'b1;
               req_data <= pending_segs.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: a result lives one cycle; compare with the oldest prediction
   always @(posedge clock) begin
      lbc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (clipped_due.size() == 0) begin
            errors++;
            $display("%0t: result expected none actual %h", $time, rsp_data);
         end else begin
            want = clipped_due.pop_front();
            if (rsp_data.accepted) accept_count++;
            if (want.accepted !== rsp_data.accepted)
               $display("%0t: accepted expected %b actual %b", $time,
                        want.accepted, rsp_data.accepted);
            if (want.clipped_start_x !== rsp_data.clipped_start_x)
               $display("%0t: start_x expected %0d actual %0d", $time,
                        want.clipped_start_x, rsp_data.clipped_start_x);
            if (want.clipped_start_y !== rsp_data.clipped_start_y)
               $display("%0t: start_y expected %0d actual %0d", $time,
                        want.clipped_start_y, rsp_data.clipped_start_y);
            if (want.clipped_end_x !== rsp_data.clipped_end_x)
               $display("%0t: end_x expected %0d actual %0d", $time,
                        want.clipped_end_x, rsp_data.clipped_end_x);
            if (want.clipped_end_y !== rsp_data.clipped_end_y)
               $display("%0t: end_y expected %0d actual %0d", $time,
                        want.clipped_end_y, rsp_data.clipped_end_y);
            if (want !== rsp_data) errors++;
         end
      end
   end

   // APB write: setup cycle, access cycle; the register takes it at the
   // edge where psel, penable and pwrite are all high
   task automatic csr_write(logic [1:0] idx, logic signed [15:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= {{16{value[15]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         lbc_pkg::REG_LEFT:   win.left = value;
         lbc_pkg::REG_RIGHT:  win.right = value;
         lbc_pkg::REG_BOTTOM: win.bottom = value;
         default:             win.top = value;
      endcase
   endtask

   task automatic set_window(int l, int r, int b, int t);
      csr_write(lbc_pkg::REG_LEFT, 16'(l));
      csr_write(lbc_pkg::REG_RIGHT, 16'(r));
      csr_write(lbc_pkg::REG_BOTTOM, 16'(b));
      csr_write(lbc_pkg::REG_TOP, 16'(t));
   endtask

   // wait until all segments are sent and results checked, then settle
   task automatic drain();
      while (pending_segs.size() > 0 || start || clipped_due.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic add_seg(lbc_pkg::req_type s);
      pending_segs = {pending_segs, s};
   endtask

   function automatic lbc_pkg::req_type seg_of(int x1, int y1, int x2, int y2);
      lbc_pkg::req_type s;
      s.start_x = 16'(x1);
      s.start_y = 16'(y1);
      s.end_x = 16'(x2);
      s.end_y = 16'(y2);
      return s;
   endfunction

   // coordinate near a window edge, clamped to the field range
   function automatic int near_edge(int e);
      int v;
      v = e + $urandom_range(0, 8) - 4;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic int pick_x();
      case ($urandom_range(0, 3))
         0: return near_edge(win.left);
         1: return near_edge(win.right);
         2: return $signed(16'($urandom));
         default: return int'($urandom_range(0, 2000)) - 1000
                         + (int'(win.left) + int'(win.right)) / 2;
      endcase
   endfunction

   function automatic int pick_y();
      case ($urandom_range(0, 3))
         0: return near_edge(win.bottom);
         1: return near_edge(win.top);
         2: return $signed(16'($urandom));
         default: return int'($urandom_range(0, 2000)) - 1000
                         + (int'(win.bottom) + int'(win.top)) / 2;
      endcase
   endfunction

   function automatic lbc_pkg::req_type random_seg();
      int x1, y1, x2, y2;
      x1 = pick_x();
      y1 = pick_y();
      x2 = pick_x();
      y2 = pick_y();
      case ($urandom_range(0, 9))
         0: x2 = x1;                       // vertical
         1: y2 = y1;                       // horizontal
         2: begin x2 = x1; y2 = y1; end    // point
         3: return lbc_pkg::req_type'({$urandom, $urandom});
         default: ;
      endcase
      return seg_of(16'(x1), 16'(y1), 16'(x2), 16'(y2));
   endfunction

   task automatic random_phase(int n);
      repeat (n) add_seg(random_seg());
      drain();
   endtask

   initial begin
      win.left = -16384;
      win.right = 16383;
      win.bottom = -16384;
      win.top = 16383;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset window, field extremes, edge cases
      add_seg(seg_of(0, 0, 100, 100));              // inside
      add_seg(seg_of(-32768, 0, 32767, 0));         // crosses both x
      add_seg(seg_of(0, -32768, 0, 32767));         // crosses both y
      add_seg(seg_of(-32768, -32768, 32767, 32767));
      add_seg(seg_of(32767, -32768, -32768, 32767));
      add_seg(seg_of(-32768, -32768, -32768, -32768));
      add_seg(seg_of(32767, 32767, 32767, 32767));
      add_seg(seg_of(5, 5, 5, 5));                  // point inside
      add_seg(seg_of(-16384, 0, -16384, 500));      // on left edge
      add_seg(seg_of(16383, -16384, 16383, 16383)); // on right edge
      add_seg(seg_of(-16385, 0, -16385, 500));      // just outside
      add_seg(seg_of(-20000, 16384, 20000, 16384)); // above, parallel
      add_seg(seg_of(-20000, -20000, -20000, 20000));
      add_seg(seg_of(-30000, 20000, -20000, 30000));// outside corner
      add_seg(seg_of(-20000, 0, 0, 20000));         // cuts corner
      add_seg(seg_of(100, 100, 30000, 30001));      // exits only
      add_seg(seg_of(30000, -30001, 0, 0));         // enters only
      add_seg(seg_of(-16384, -16384, 16383, 16383));// corner to corner
      add_seg(seg_of(16384, 0, -16385, 1));
      add_seg(seg_of(-1, -1, 0, 0));
      drain();

      random_phase(110);
      set_window(-32768, 32767, -32768, 32767);   // whole plane
      random_phase(110);
      set_window(32767, -32768, 32767, -32768);   // inverted extremes
      random_phase(90);
      set_window(0, 0, 0, 0);                     // single point window
      add_seg(seg_of(0, 0, 0, 0));
      add_seg(seg_of(-5, -5, 5, 5));
      random_phase(90);
      set_window(100, -100, -3000, 3000);         // x inverted only
      random_phase(80);
      set_window($urandom_range(0, 8000) - 12000, $urandom_range(0, 8000) + 2000,
                 $urandom_range(0, 8000) - 12000, $urandom_range(0, 8000) + 2000);
      random_phase(110);
      calm = 1'b1;                                // back-to-back tail
      set_window(-32768, -32768, 32767, 32767);
      random_phase(40);
      set_window(-20000, 1000, -500, 25000);
      random_phase(80);

      $display("%0d segments clipped under 8 window settings, %0d accepted.",
               seg_count, accept_count);
      $display("%0d results checked, %0d errors.", rsp_count, errors);
      if (errors == 0 && clipped_due.size() == 0)
         $display("liang_barsky_line_clipper_test: done, clean");
      else
         $display("liang_barsky_line_clipper_test: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d results still due", clipped_due.size());
      $display("liang_barsky_line_clipper_test: done, errors");
      $finish;
   end
endmodule

### sim.f
src/lbc_pkg.sv
src/lbc_front.sv
src/lbc_fifo.sv
src/lbc_divider.sv
src/lbc_back.sv
src/liang_barsky_line_clipper.sv
tb/liang_barsky_line_clipper_test.sv
